FILE: sv/ama_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ama_pkg
// shared widths, angle constants and cordic helpers for the attitude block
// ----------------------------------------------------------------------------
package ama_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int SQ_W          = 2 * SAMPLE_BITS;
    localparam int RAD_W         = SQ_W + 16;
    localparam int ROOT_W        = RAD_W / 2;
    localparam int REM_W         = ROOT_W + 2;
    localparam int VEC_W         = ROOT_W + 2;
    localparam int CW            = VEC_W + 22;
    localparam int ZW            = 34;
    localparam int ISQ_STAGES    = ROOT_W;

    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd9000 * 64'sd65536);
    localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'sd18000 * 64'sd65536);
    localparam logic signed [ZW-1:0] FULL_TURN    = ZW'(64'sd36000 * 64'sd65536);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } t_vec;

    function automatic logic signed [ZW-1:0] arc_entry(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = ZW'(64'sd294912000);
            1:       v = ZW'(64'sd174096719);
            2:       v = ZW'(64'sd91987925);
            3:       v = ZW'(64'sd46694507);
            4:       v = ZW'(64'sd23437865);
            5:       v = ZW'(64'sd11730358);
            6:       v = ZW'(64'sd5866610);
            7:       v = ZW'(64'sd2933484);
            8:       v = ZW'(64'sd1466764);
            9:       v = ZW'(64'sd733385);
            10:      v = ZW'(64'sd366693);
            11:      v = ZW'(64'sd183346);
            12:      v = ZW'(64'sd91673);
            13:      v = ZW'(64'sd45837);
            14:      v = ZW'(64'sd22918);
            15:      v = ZW'(64'sd11459);
            16:      v = ZW'(64'sd5730);
            17:      v = ZW'(64'sd2865);
            18:      v = ZW'(64'sd1432);
            19:      v = ZW'(64'sd716);
            20:      v = ZW'(64'sd358);
            21:      v = ZW'(64'sd179);
            22:      v = ZW'(64'sd90);
            23:      v = ZW'(64'sd45);
            default: v = '0;
        endcase
        return v;
    endfunction

    // quadrant pre-rotation and scaling
    function automatic t_vec cordic_prep(input logic signed [VEC_W-1:0] y_in,
                                         input logic signed [VEC_W-1:0] x_in);
        t_vec                 r;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        xs = {{(CW-VEC_W-20){x_in[VEC_W-1]}}, x_in, 20'b0};
        ys = {{(CW-VEC_W-20){y_in[VEC_W-1]}}, y_in, 20'b0};
        r.zero = (x_in == '0) && (y_in == '0);
        r.x = xs;
        r.y = ys;
        r.z = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                r.x = ys;
                r.y = -xs;
                r.z = QUARTER_TURN;
            end else begin
                r.x = -ys;
                r.y = xs;
                r.z = -QUARTER_TURN;
            end
        end
        return r;
    endfunction

    function automatic t_vec cordic_step(input t_vec v, input int idx);
        t_vec                 r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        dx = v.y >>> idx;
        dy = v.x >>> idx;
        r = v;
        if (v.y > 0) begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + arc_entry(idx);
        end else begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - arc_entry(idx);
        end
        return r;
    endfunction

    // centidegrees, truncated toward zero
    function automatic logic signed [ZW-17:0] to_cdeg(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] m;
        logic signed [ZW-1:0] q;
        m = (z < 0) ? -z : z;
        q = m >>> 16;
        if (z < 0) begin
            q = -q;
        end
        return q[ZW-17:0];
    endfunction

endpackage

FILE: sv/ama_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ama interfaces
// valid/ready channels for sensor items, angle items and the declination write
// ----------------------------------------------------------------------------
interface ama_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] mag_raw_x;
    logic signed [15:0] mag_raw_y;
    modport source (output valid, accel_x, accel_y, accel_z, mag_raw_x, mag_raw_y,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, mag_raw_x, mag_raw_y,
                    output ready);
endinterface

interface ama_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] heading_cdeg;
    logic signed [14:0] pitch_cdeg;
    logic signed [15:0] roll_cdeg;
    modport source (output valid, heading_cdeg, pitch_cdeg, roll_cdeg, input ready);
    modport sink   (input valid, heading_cdeg, pitch_cdeg, roll_cdeg, output ready);
endinterface

interface ama_cfg_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: sv/accel_mag_attitude_angles.sv
`timescale 1ns / 1ps
// path to result valid: front, square root, cordic entry, cordic and post stages
// throughput: one item per cycle, whole pipeline holds while the output is stalled
// depth set by the 24-stage square root followed by the 16-stage cordic
// reset: valid bits cleared, declination returns to zero
// ----------------------------------------------------------------------------
// accel_mag_attitude_angles
// roll, pitch and heading from one accel and mag sample via pipelined cordic
// ----------------------------------------------------------------------------
module accel_mag_attitude_angles (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ama_in_if.sink    s_in,
    ama_out_if.source m_out,
    ama_cfg_if.sink   s_cfg
);

    localparam int NI = ama_pkg::ISQ_STAGES;
    localparam int NC = ama_pkg::CORDIC_STAGES;
    localparam int SB = ama_pkg::SAMPLE_BITS;

    logic w_adv;

    logic signed [15:0] r_decl;

    // front stages
    logic                          r_v0, r_v1;
    logic signed [SB-1:0]          r0_ax, r0_ay, r0_az;
    logic signed [SB:0]            r0_mx, r0_my;
    logic [ama_pkg::SQ_W-1:0]      r0_sy, r0_sz;

    logic signed [SB-1:0]          w_ay, w_az;
    logic signed [ama_pkg::SQ_W-1:0] w_sqy, w_sqz;

    // square root stages
    logic                          r_sv   [0:NI];
    logic [ama_pkg::RAD_W-1:0]     r_rad  [0:NI];
    logic [ama_pkg::REM_W-1:0]     r_rem  [0:NI];
    logic [ama_pkg::ROOT_W-1:0]    r_root [0:NI];
    logic signed [SB-1:0]          r_sax  [0:NI];
    logic signed [SB-1:0]          r_say  [0:NI];
    logic signed [SB-1:0]          r_saz  [0:NI];
    logic signed [SB:0]            r_smx  [0:NI];
    logic signed [SB:0]            r_smy  [0:NI];

    // cordic stages
    logic                          r_cv   [0:NC];
    ama_pkg::t_vec                 r_roll [0:NC];
    ama_pkg::t_vec                 r_pit  [0:NC];
    ama_pkg::t_vec                 r_head [0:NC];
    logic                          r_myz  [0:NC];
    logic                          r_mxn  [0:NC];

    // post stages
    logic                          r_pv, r_ov;
    logic signed [ama_pkg::ZW-1:0] r_ph, r_pp, r_pr;
    logic signed [15:0]            r_oh, r_or;
    logic signed [14:0]            r_op;

    logic signed [ama_pkg::ZW-1:0] n_head;
    logic signed [ama_pkg::ZW-1:0] w_hz;
    logic signed [ama_pkg::ZW-17:0] w_ch, w_cp, w_cr;

    assign w_adv       = !r_ov || m_out.ready;
    assign s_in.ready  = w_adv;
    assign s_cfg.ready = 1'b1;

    assign m_out.valid        = r_ov;
    assign m_out.heading_cdeg = r_oh;
    assign m_out.pitch_cdeg   = r_op;
    assign m_out.roll_cdeg    = r_or;

    assign w_ay  = signed'(s_in.accel_y[SB-1:0]);
    assign w_az  = signed'(s_in.accel_z[SB-1:0]);
    assign w_sqy = w_ay * w_ay;
    assign w_sqz = w_az * w_az;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= '0;
        end else if (s_cfg.valid) begin
            r_decl <= s_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v0 <= s_in.valid;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_ax <= s_in.accel_x[SB-1:0];
            r0_ay <= s_in.accel_y[SB-1:0];
            r0_az <= s_in.accel_z[SB-1:0];
            r0_mx <= -(SB+1)'(signed'(s_in.mag_raw_y[SB-1:0]));
            r0_my <= -(SB+1)'(signed'(s_in.mag_raw_x[SB-1:0]));
            r0_sy <= $unsigned(w_sqy);
            r0_sz <= $unsigned(w_sqz);
            r_rad[0]  <= {r0_sy + r0_sz, 16'b0};
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_sax[0]  <= r0_ax;
            r_say[0]  <= r0_ay;
            r_saz[0]  <= r0_az;
            r_smx[0]  <= r0_mx;
            r_smy[0]  <= r0_my;
        end
    end

    assign r_sv[0] = r_v1;

    genvar k;
    generate
        for (k = 0; k < NI; k++) begin : g_isq
            logic [ama_pkg::REM_W-1:0] w_cur;
            logic [ama_pkg::REM_W-1:0] w_try;
            assign w_cur = {r_rem[k][ama_pkg::REM_W-3:0],
                            r_rad[k][ama_pkg::RAD_W-1 -: 2]};
            assign w_try = {r_root[k], 2'b01};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sv[k+1] <= 1'b0;
                end else if (w_adv) begin
                    r_sv[k+1] <= r_sv[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_rad[k+1] <= {r_rad[k][ama_pkg::RAD_W-3:0], 2'b00};
                    if (w_cur >= w_try) begin
                        r_rem[k+1]  <= w_cur - w_try;
                        r_root[k+1] <= {r_root[k][ama_pkg::ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem[k+1]  <= w_cur;
                        r_root[k+1] <= {r_root[k][ama_pkg::ROOT_W-2:0], 1'b0};
                    end
                    r_sax[k+1] <= r_sax[k];
                    r_say[k+1] <= r_say[k];
                    r_saz[k+1] <= r_saz[k];
                    r_smx[k+1] <= r_smx[k];
                    r_smy[k+1] <= r_smy[k];
                end
            end
        end
    endgenerate

    // cordic entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (w_adv) begin
            r_cv[0] <= r_sv[NI];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_roll[0] <= ama_pkg::cordic_prep(
                {{(ama_pkg::VEC_W-SB-8){r_say[NI][SB-1]}}, r_say[NI], 8'b0},
                {{(ama_pkg::VEC_W-SB-8){r_saz[NI][SB-1]}}, r_saz[NI], 8'b0});
            r_pit[0] <= ama_pkg::cordic_prep(
                -{{(ama_pkg::VEC_W-SB-8){r_sax[NI][SB-1]}}, r_sax[NI], 8'b0},
                {{(ama_pkg::VEC_W-ama_pkg::ROOT_W){1'b0}}, r_root[NI]});
            r_head[0] <= ama_pkg::cordic_prep(
                {{(ama_pkg::VEC_W-SB-9){r_smx[NI][SB]}}, r_smx[NI], 8'b0},
                {{(ama_pkg::VEC_W-SB-9){r_smy[NI][SB]}}, r_smy[NI], 8'b0});
            r_myz[0] <= (r_smy[NI] == '0);
            r_mxn[0] <= r_smx[NI][SB];
        end
    end

    genvar j;
    generate
        for (j = 0; j < NC; j++) begin : g_cordic
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cv[j+1] <= 1'b0;
                end else if (w_adv) begin
                    r_cv[j+1] <= r_cv[j];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_roll[j+1] <= ama_pkg::cordic_step(r_roll[j], j);
                    r_pit[j+1]  <= ama_pkg::cordic_step(r_pit[j], j);
                    r_head[j+1] <= ama_pkg::cordic_step(r_head[j], j);
                    r_myz[j+1]  <= r_myz[j];
                    r_mxn[j+1]  <= r_mxn[j];
                end
            end
        end
    endgenerate

    // heading special case, declination and wrap
    always_comb begin
        if (r_myz[NC]) begin
            w_hz = r_mxn[NC] ? ama_pkg::HALF_TURN : '0;
        end else begin
            w_hz = r_head[NC].z;
        end
        n_head = w_hz - {{(ama_pkg::ZW-32){r_decl[15]}}, r_decl, 16'b0};
        if (n_head > ama_pkg::HALF_TURN) begin
            n_head = n_head - ama_pkg::FULL_TURN;
        end else if (n_head < -ama_pkg::HALF_TURN) begin
            n_head = n_head + ama_pkg::FULL_TURN;
        end
    end

    assign w_ch = ama_pkg::to_cdeg(r_ph);
    assign w_cp = ama_pkg::to_cdeg(r_pp);
    assign w_cr = ama_pkg::to_cdeg(r_pr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_pv <= r_cv[NC];
            r_ov <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ph <= n_head;
            r_pp <= r_pit[NC].zero ? '0 : r_pit[NC].z;
            r_pr <= r_roll[NC].zero ? '0 : r_roll[NC].z;
            r_oh <= w_ch[15:0];
            r_op <= w_cp[14:0];
            r_or <= w_cr[15:0];
        end
    end

endmodule
